@@ design/tfn_pkg.sv @@
// Package for the triangle flat normal core.
// Holds default parameters, port widths and the register reset value.
// No dependencies.
package tfn_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 14;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned OUT_W           = 16;
  localparam logic [CFG_W-1:0] MIN_LEN_RESET = 16'd2684;

endpackage

@@ design/triangle_flat_normal_core.sv @@
// Triangle flat normal core: cross product, square root chain, divider chain.
// The square root and divider chains resolve one bit per cell. Throughput: one
// triangle per cycle; a stalled output holds the whole pipeline.
// Reset clears all valid bits and loads min_length with 2684.
// Depends on tfn_pkg, tfn_sqrt_cell and tfn_div_cell.
module triangle_flat_normal_core #(
  parameter int unsigned COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = tfn_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tfn_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] first_z_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_z_i,
  input  logic signed [COORD_WIDTH-1:0] third_x_i,
  input  logic signed [COORD_WIDTH-1:0] third_y_i,
  input  logic signed [COORD_WIDTH-1:0] third_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [tfn_pkg::OUT_W-1:0] normal_x_o,
  output logic signed [tfn_pkg::OUT_W-1:0] normal_y_o,
  output logic signed [tfn_pkg::OUT_W-1:0] normal_z_o,
  output logic                          degenerate_o
);
  import tfn_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned EW  = W + 1;          // edge
  localparam int unsigned PW  = 2 * W + 2;      // edge product
  localparam int unsigned MW  = 2 * W + 2;      // cross magnitude
  localparam int unsigned SW  = 4 * W + 4;      // sum of squares
  localparam int unsigned RW  = 2 * W + 2;      // root
  localparam int unsigned QW  = F + 1;          // output magnitude
  localparam int unsigned NW  = RW + F + 1;     // dividend
  localparam int unsigned XW  = QW + OUT_W;     // signed result before cut
  localparam int unsigned SDW = 3 * MW + 3 + 3 * QW;
  localparam int unsigned DDW = 3 + 3 * QW + 1;

  logic adv;
  logic [CFG_W-1:0] min_len_q;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RESET;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  // front pipeline valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q} <= '0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // edges u = b - a, v = c - a
  logic signed [EW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [PW-1:0] p_q [6];
  logic signed [PW:0]   n_s [3];
  logic [2:0][MW-1:0]   m_d, m_q, m4_q, m5_q;
  logic [2:0]           neg_q, neg4_q, neg5_q;
  logic [2:0][QW-1:0]   dq_d, dq_q, dq4_q, dq5_q;
  logic [2:0][SW-1:0]   sq_q;
  logic [SW-1:0]        sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux_q <= EW'(second_x_i) - EW'(first_x_i);
      uy_q <= EW'(second_y_i) - EW'(first_y_i);
      uz_q <= EW'(second_z_i) - EW'(first_z_i);
      vx_q <= EW'(third_x_i) - EW'(first_x_i);
      vy_q <= EW'(third_y_i) - EW'(first_y_i);
      vz_q <= EW'(third_z_i) - EW'(first_z_i);
    end
  end

  // edge products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= PW'(uy_q * vz_q);
      p_q[1] <= PW'(uz_q * vy_q);
      p_q[2] <= PW'(uz_q * vx_q);
      p_q[3] <= PW'(ux_q * vz_q);
      p_q[4] <= PW'(ux_q * vy_q);
      p_q[5] <= PW'(uy_q * vx_q);
    end
  end

  // cross product, magnitude, sign and unnormalized rescale
  logic [MW:0] rnd_s [3];
  logic [MW:0] shr_s [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_s[k]   = (PW + 1)'(p_q[2 * k]) - (PW + 1)'(p_q[2 * k + 1]);
      m_d[k]   = n_s[k][PW] ? MW'(-n_s[k]) : MW'(n_s[k]);
      rnd_s[k] = (MW + 1)'(m_d[k]) + ((MW + 1)'(1) << (F - 1));
      shr_s[k] = rnd_s[k] >> F;
      dq_d[k]  = (shr_s[k] > ((MW + 1)'(1) << F)) ? (QW'(1) << F) : QW'(shr_s[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        neg_q[k] <= n_s[k][PW];
      end
      m_q  <= m_d;
      dq_q <= dq_d;
    end
  end

  // squares, then their sum
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= SW'(m_q[k]) * SW'(m_q[k]);
      end
      m4_q   <= m_q;
      neg4_q <= neg_q;
      dq4_q  <= dq_q;
      sum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      m5_q   <= m4_q;
      neg5_q <= neg4_q;
      dq5_q  <= dq4_q;
    end
  end

  // square root chain, top bit first
  logic          sv   [RW+1];
  logic [SW-1:0] srem [RW+1];
  logic [RW-1:0] sroot[RW+1];
  logic [SDW-1:0] sdat[RW+1];

  assign sv[0]    = v5_q;
  assign srem[0]  = sum_q;
  assign sroot[0] = '0;
  assign sdat[0]  = {m5_q, neg5_q, dq5_q};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    tfn_sqrt_cell #(.SW(SW), .RW(RW), .BIT(RW - 1 - i), .DW(SDW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(sv[i]),
      .rem_i  (srem[i]),
      .root_i (sroot[i]),
      .data_i (sdat[i]),
      .valid_o(sv[i+1]),
      .rem_o  (srem[i+1]),
      .root_o (sroot[i+1]),
      .data_o (sdat[i+1])
    );
  end

  // threshold compare and dividend setup
  logic [2:0][MW-1:0] sm;
  logic [2:0]         sneg;
  logic [2:0][QW-1:0] sdq;
  logic [RW-1:0]      len;
  logic               pv_q, pdeg_q;
  logic [RW-1:0]      plen_q;
  logic [2:0][NW-1:0] pn_q;
  logic [2:0]         pneg_q;
  logic [2:0][QW-1:0] pdq_q;
  logic [2:0][MW-1:0] pm_q;

  assign {sm, sneg, sdq} = sdat[RW];
  assign len = sroot[RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (adv) begin
      pv_q <= sv[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pdeg_q <= !(len > RW'(min_len_q));
      plen_q <= len;
      for (int k = 0; k < 3; k++) begin
        pn_q[k] <= (NW'(sm[k]) << F) + NW'(len >> 1);
      end
      pneg_q <= sneg;
      pdq_q  <= sdq;
      pm_q   <= sm;
    end
  end

  // divider chain, top quotient bit first
  logic               dv   [QW+1];
  logic [RW-1:0]      dlen [QW+1];
  logic [2:0][NW-1:0] drem [QW+1];
  logic [2:0][QW-1:0] dquo [QW+1];
  logic [DDW-1:0]     ddat [QW+1];

  assign dv[0]   = pv_q;
  assign dlen[0] = plen_q;
  assign drem[0] = pn_q;
  assign dquo[0] = '0;
  assign ddat[0] = {pneg_q, pdq_q, pdeg_q};

  for (genvar j = 0; j < QW; j++) begin : g_div
    tfn_div_cell #(.NW(NW), .LW(RW), .QW(QW), .BIT(QW - 1 - j), .DW(DDW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(dv[j]),
      .len_i  (dlen[j]),
      .rem_i  (drem[j]),
      .quo_i  (dquo[j]),
      .data_i (ddat[j]),
      .valid_o(dv[j+1]),
      .len_o  (dlen[j+1]),
      .rem_o  (drem[j+1]),
      .quo_o  (dquo[j+1]),
      .data_o (ddat[j+1])
    );
  end

  // select path, apply sign, cut to output width
  logic [2:0]         fneg;
  logic [2:0][QW-1:0] fdq;
  logic               fdeg;
  logic [2:0][XW-1:0] fval;
  logic [2:0][OUT_W-1:0] res_q;
  logic               deg_q, ov_q;

  assign {fneg, fdq, fdeg} = ddat[QW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fval[k] = XW'(fdeg ? fdq[k] : dquo[QW][k]);
      if (fneg[k]) begin
        fval[k] = -fval[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= dv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        res_q[k] <= fval[k][OUT_W-1:0];
      end
      deg_q <= fdeg;
    end
  end

  assign out_valid_o  = ov_q;
  assign normal_x_o   = res_q[0];
  assign normal_y_o   = res_q[1];
  assign normal_z_o   = res_q[2];
  assign degenerate_o = deg_q;

  // a cross product magnitude never exceeds the root
  a_mag_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q && !pdeg_q |-> pm_q[0] <= MW'(plen_q) && pm_q[1] <= MW'(plen_q)
                        && pm_q[2] <= MW'(plen_q))
    else $error("cross magnitude above root");

  // the divider quotient stays within one
  a_quo_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[QW] && !fdeg |-> dquo[QW][0] <= (QW'(1) << F) && dquo[QW][1] <= (QW'(1) << F)
                        && dquo[QW][2] <= (QW'(1) << F))
    else $error("quotient above one");

  // a held output does not let the pipeline move
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(deg_q))
    else $error("output changed while stalled");

endmodule

@@ design/tfn_sqrt_cell.sv @@
// One square root chain cell: resolves one root bit per cycle while enabled.
// Depends on nothing besides its parameters.
module tfn_sqrt_cell #(
  parameter int unsigned SW  = 68,
  parameter int unsigned RW  = 34,
  parameter int unsigned BIT = 0,
  parameter int unsigned DW  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [SW-1:0] rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [DW-1:0] data_i,
  output logic          valid_o,
  output logic [SW-1:0] rem_o,
  output logic [RW-1:0] root_o,
  output logic [DW-1:0] data_o
);

  logic          valid_q;
  logic [SW-1:0] rem_q, rem_d, trial;
  logic [RW-1:0] root_q, root_d;
  logic [DW-1:0] data_q;

  // trial subtrahend (2*root + 2^BIT) * 2^BIT; root has no bits at or below BIT
  assign trial = (SW'(root_i) << (BIT + 1)) | (SW'(1) << (2 * BIT));

  always_comb begin
    rem_d  = rem_i;
    root_d = root_i;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = root_i | (RW'(1) << BIT);
    end
  end

  // advance valid with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign data_o  = data_q;

endmodule

@@ design/tfn_div_cell.sv @@
// One cell of the restoring divider chain: one quotient bit for each of
// the three components per cycle while enabled. Depends on parameters only.
module tfn_div_cell #(
  parameter int unsigned NW  = 49,
  parameter int unsigned LW  = 34,
  parameter int unsigned QW  = 15,
  parameter int unsigned BIT = 0,
  parameter int unsigned DW  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [LW-1:0]        len_i,
  input  logic [2:0][NW-1:0]   rem_i,
  input  logic [2:0][QW-1:0]   quo_i,
  input  logic [DW-1:0]        data_i,
  output logic                 valid_o,
  output logic [LW-1:0]        len_o,
  output logic [2:0][NW-1:0]   rem_o,
  output logic [2:0][QW-1:0]   quo_o,
  output logic [DW-1:0]        data_o
);

  logic               valid_q;
  logic [LW-1:0]      len_q;
  logic [2:0][NW-1:0] rem_q, rem_d;
  logic [2:0][QW-1:0] quo_q, quo_d;
  logic [DW-1:0]      data_q;
  logic [NW-1:0]      dvs;

  assign dvs = NW'(len_i) << BIT;

  // subtract the shifted divisor where it fits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_d[k] = rem_i[k];
      quo_d[k] = quo_i[k];
      if (rem_i[k] >= dvs) begin
        rem_d[k] = rem_i[k] - dvs;
        quo_d[k] = quo_i[k] | (QW'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q  <= len_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign len_o   = len_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign data_o  = data_q;

endmodule

@@ bench/testbench.sv @@
// Testbench for triangle_flat_normal_core: random and directed triangles, checked
// against an in-bench bit-exact model of the face normal and degenerate flag.
// Depends on tfn_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW   = tfn_pkg::COORD_WIDTH_DEF;
  localparam int unsigned FB   = tfn_pkg::FRAC_BITS_DEF;
  localparam int unsigned OW   = tfn_pkg::OUT_W;
  localparam int unsigned LAT  = 2 * CW + FB + 10;

  // one triangle: a xyz, b xyz, c xyz
  typedef struct {
    logic signed [CW-1:0] crd[9];
  } triangle_t;

  typedef struct {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic [OW-1:0] nz;
    logic          deg;
  } normal_t;

  class normal_scoreboard;
    normal_t                 expected_normals[$];
    logic [tfn_pkg::CFG_W-1:0] min_len;
    int                      mismatches;
    int                      checked;
    int                      degenerate_seen;

    function new();
      min_len = tfn_pkg::MIN_LEN_RESET;
      mismatches = 0;
      checked = 0;
      degenerate_seen = 0;
    endfunction

    // saturate the magnitude at one, then apply sign
    function automatic logic [OW-1:0] signed_component(bit neg, logic [63:0] q);
      logic [63:0] lim;
      lim = 64'd1 << FB;
      if (q > lim) q = lim;
      return neg ? OW'(-q) : OW'(q);
    endfunction

    function automatic normal_t compute_normal(triangle_t t);
      longint      u[3];
      longint      v[3];
      longint      n[3];
      logic [63:0] m[3];
      logic [127:0] sq_sum;
      logic [127:0] trial;
      logic [63:0] root;
      logic [63:0] q;
      normal_t     res;
      logic [OW-1:0] comp[3];
      for (int k = 0; k < 3; k++) begin
        u[k] = longint'(t.crd[3+k]) - longint'(t.crd[k]);
        v[k] = longint'(t.crd[6+k]) - longint'(t.crd[k]);
      end
      n[0] = u[1] * v[2] - u[2] * v[1];
      n[1] = u[2] * v[0] - u[0] * v[2];
      n[2] = u[0] * v[1] - u[1] * v[0];
      sq_sum = '0;
      for (int k = 0; k < 3; k++) begin
        m[k] = (n[k] < 0) ? 64'(-n[k]) : 64'(n[k]);
        sq_sum += 128'(m[k]) * 128'(m[k]);
      end
      // floor square root, one bit at a time
      root = '0;
      for (int b = 62; b >= 0; b--) begin
        trial = 128'(root | (64'd1 << b));
        if (trial * trial <= sq_sum) root = root | (64'd1 << b);
      end
      res.deg = !(root > 64'(min_len));
      for (int k = 0; k < 3; k++) begin
        if (!res.deg) q = ((m[k] << FB) + (root >> 1)) / root;
        else q = (m[k] + (64'd1 << (FB - 1))) >> FB;
        comp[k] = signed_component(n[k] < 0, q);
      end
      res.nx = comp[0];
      res.ny = comp[1];
      res.nz = comp[2];
      return res;
    endfunction

    function void note_triangle(triangle_t t);
      expected_normals.insert(expected_normals.size(), compute_normal(t));
    endfunction

    function void check_normal(normal_t got);
      normal_t exp_n;
      if (expected_normals.size() == 0) begin
        $error("normal result with no triangle outstanding");
        mismatches++;
        return;
      end
      exp_n = expected_normals.pop_front();
      checked++;
      if (exp_n.deg) degenerate_seen++;
      if (got.nx !== exp_n.nx) begin
        $error("normal_x expected %0d got %0d", $signed(exp_n.nx), $signed(got.nx));
        mismatches++;
      end
      if (got.ny !== exp_n.ny) begin
        $error("normal_y expected %0d got %0d", $signed(exp_n.ny), $signed(got.ny));
        mismatches++;
      end
      if (got.nz !== exp_n.nz) begin
        $error("normal_z expected %0d got %0d", $signed(exp_n.nz), $signed(got.nz));
        mismatches++;
      end
      if (got.deg !== exp_n.deg) begin
        $error("degenerate expected %0d got %0d", exp_n.deg, got.deg);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [tfn_pkg::CFG_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [CW-1:0] crd_i[9];
  logic out_valid_o;
  logic out_ready_i;
  logic signed [OW-1:0] normal_x_o;
  logic signed [OW-1:0] normal_y_o;
  logic signed [OW-1:0] normal_z_o;
  logic degenerate_o;

  normal_scoreboard normals = new();
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          triangles_sent;
  int          cfg_writes;

  triangle_flat_normal_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .first_x_i   (crd_i[0]),
    .first_y_i   (crd_i[1]),
    .first_z_i   (crd_i[2]),
    .second_x_i  (crd_i[3]),
    .second_y_i  (crd_i[4]),
    .second_z_i  (crd_i[5]),
    .third_x_i   (crd_i[6]),
    .third_y_i   (crd_i[7]),
    .third_z_i   (crd_i[8]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .normal_x_o  (normal_x_o),
    .normal_y_o  (normal_y_o),
    .normal_z_o  (normal_z_o),
    .degenerate_o(degenerate_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop if the core hangs
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // sample results and randomly throttle the output side
  always @(posedge clk_i) begin
    normal_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.nx = normal_x_o;
      got.ny = normal_y_o;
      got.nz = normal_z_o;
      got.deg = degenerate_o;
      normals.check_normal(got);
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // present one triangle, hold it until the transfer
  task automatic send_triangle(triangle_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int k = 0; k < 9; k++) crd_i[k] <= t.crd[k];
    do @(posedge clk_i); while (!in_ready_o);
    normals.note_triangle(t);
    triangles_sent++;
  endtask

  // hold off until every result is back, then let the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (normals.expected_normals.size() != 0);
    repeat (LAT + 8) @(posedge clk_i);
  endtask

  task automatic write_min_length(logic [tfn_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    normals.min_len = val;
    cfg_writes++;
  endtask

  function automatic logic signed [CW-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return -16'sd32768;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // random triangle: broad, span-limited, collinear, extreme-corner or tiny
  function automatic triangle_t random_triangle();
    triangle_t t;
    int unsigned span;
    int          d;
    for (int k = 0; k < 3; k++) t.crd[k] = CW'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: for (int k = 3; k < 9; k++) t.crd[k] = CW'($urandom);
      4, 5, 6: begin
        span = 1 << $urandom_range(12);
        for (int k = 3; k < 9; k++)
          t.crd[k] = t.crd[k % 3] + CW'(int'($urandom_range(2 * span)) - int'(span));
      end
      7: begin
        for (int k = 0; k < 3; k++) begin
          d = int'($urandom_range(2000)) - 1000;
          t.crd[3+k] = t.crd[k] + CW'(d);
          t.crd[6+k] = t.crd[k] + CW'(2 * d);
        end
      end
      8: for (int k = 0; k < 9; k++) t.crd[k] = pick_extreme();
      default:
        for (int k = 3; k < 9; k++)
          t.crd[k] = t.crd[k % 3] + CW'(int'($urandom_range(6)) - 3);
    endcase
    return t;
  endfunction

  function automatic triangle_t make_triangle(int a0, int a1, int a2, int b0, int b1,
                                              int b2, int c0, int c1, int c2);
    triangle_t t;
    t.crd[0] = CW'(a0); t.crd[1] = CW'(a1); t.crd[2] = CW'(a2);
    t.crd[3] = CW'(b0); t.crd[4] = CW'(b1); t.crd[5] = CW'(b2);
    t.crd[6] = CW'(c0); t.crd[7] = CW'(c1); t.crd[8] = CW'(c2);
    return t;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_triangle(random_triangle());
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    out_ready_i   = 1'b0;
    for (int k = 0; k < 9; k++) crd_i[k] = '0;
    send_idle_pct  = 10;
    recv_idle_pct  = 54;
    triangles_sent = 0;
    cfg_writes     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero area, unit axes, extremes, tiny and collinear faces
    send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_triangle(0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    send_triangle(make_triangle(0, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_triangle(make_triangle(0, 0, 0, 0, 0, 16384, 16384, 0, 0));
    send_triangle(make_triangle(-32768, -32768, -32768, 32767, -32768, -32768,
                                -32768, 32767, -32768));
    send_triangle(make_triangle(32767, 32767, 32767, -32768, 32767, 32767,
                                32767, -32768, 32767));
    send_triangle(make_triangle(-32768, 32767, -32768, 32767, -32768, 32767,
                                32767, 32767, -32768));
    send_triangle(make_triangle(-32768, -32768, -32768, 32767, 32767, 32767,
                                -32768, 32767, 32767));
    send_triangle(make_triangle(100, 200, 300, 101, 200, 300, 100, 201, 300));
    send_triangle(make_triangle(0, 0, 0, 1, 2, 3, 2, 4, 6));
    send_triangle(make_triangle(5, 5, 5, 5, 5, 5, 9, 9, 9));
    send_triangle(make_triangle(0, 0, 0, 52, 0, 0, 0, 52, 0));
    send_triangle(make_triangle(0, 0, 0, 51, 0, 0, 0, 52, 0));
    send_triangle(make_triangle(0, 0, 0, 3, 1, 0, 1, 3, 0));
    send_triangle(make_triangle(-1, -1, -1, 32767, 0, -32768, 0, -32768, 32767));
    send_triangle(make_triangle(1000, -2000, 3000, -4000, 5000, -6000,
                                7000, 8000, -9000));
    drain();

    // phase 1: sender idles lightly, receiver heavily
    write_min_length(16'd0);
    run_random(250);
    drain();
    write_min_length(16'hFFFF);
    run_random(220);
    drain();

    // phase 2: roles swapped
    send_idle_pct = 54;
    recv_idle_pct = 10;
    write_min_length(tfn_pkg::MIN_LEN_RESET);
    run_random(230);
    drain();
    write_min_length(16'($urandom));
    run_random(230);
    drain();

    // phase 3: full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_min_length(16'd1);
    run_random(230);
    drain();
    write_min_length(16'($urandom_range(4096)));
    run_random(230);
    drain();

    $display("Covered %0d triangles (%0d degenerate) across %0d threshold settings.",
             triangles_sent, normals.degenerate_seen, cfg_writes + 1);
    $display("Checked %0d normals, %0d field mismatches.", normals.checked,
             normals.mismatches);
    if (normals.mismatches == 0 && normals.expected_normals.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tfn_pkg.sv
design/tfn_sqrt_cell.sv
design/tfn_div_cell.sv
design/triangle_flat_normal_core.sv
bench/testbench.sv
